### rtl/sfs_pkg.sv
`timescale 1ns / 1ps

package sfs_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int INDEX_W     = 3;
    localparam int LATCH_EVERY = 3;

    localparam logic [7:0] HDR0         = 8'hBC;
    localparam logic [7:0] HDR1         = 8'h02;
    localparam logic [7:0] RELOAD_RESET = 8'd10;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_READY = 1'b1;

    typedef logic [FRAME_BYTES-1:0][7:0] t_frame_row;

    typedef struct packed {
        logic       func;
        logic [5:0] status_flags;
        logic [7:0] speed_level;
        logic [7:0] battery_level;
        logic [7:0] sensed_value;
        logic [7:0] logo_byte;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]         tx_byte;
        logic [INDEX_W-1:0] byte_index;
        logic               frame_last;
    } t_out_beat;

endpackage

### rtl/sfs_frame_buf.sv
`timescale 1ns / 1ps

module sfs_frame_buf (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr_en,
    input  sfs_pkg::t_frame_row              i_wr_row,
    input  logic                             i_rd_en,
    input  logic [sfs_pkg::INDEX_W-1:0]      i_rd_addr,
    output logic [7:0]                       o_rd_data
);

    // One frame row, written whole and read one byte at a time.
    sfs_pkg::t_frame_row r_row;
    logic                r_written;
    logic [7:0]          r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= 1'b0;
        end else if (i_wr_en) begin
            r_written <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_row <= i_wr_row;
        end
    end

    // The row reads as all zero until the first frame has been built.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_written ? r_row[i_rd_addr] : 8'd0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/status_frame_sender.sv
`timescale 1ns / 1ps

// Periodic telemetry frame sender. Each input beat is a pacing tick or a
// transmitter-ready event; a tick that finds the pacing counter at zero
// reloads it, builds an 8-byte frame (header, status, levels, sensed value,
// logo byte, checksum) into the frame buffer and sends byte 0, and each ready
// beat sends the next byte until the checksum is out; a ready beat after that
// only rewinds the index. The block takes one beat per clock; a result passes
// through the frame buffer read stage and then the output register. The input
// side stalls only when both the read stage and the output register hold
// beats and the output is stalled.
module status_frame_sender (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sfs_pkg::t_in_beat   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sfs_pkg::t_out_beat  o_out_data,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_wdata
);

    localparam logic [1:0] LATCH_PHASE = 2'(sfs_pkg::LATCH_EVERY);

    logic [7:0] r_reload;
    logic [7:0] r_pacing_count;
    logic [1:0] r_phase;
    logic [7:0] r_latched;
    logic [3:0] r_send_index;

    logic                          r_s1_valid;
    logic                          r_s1_direct;
    logic [sfs_pkg::INDEX_W-1:0]   r_s1_index;

    logic                r_out_valid;
    sfs_pkg::t_out_beat  r_out_data;

    logic                 in_acc;
    logic                 is_tick;
    logic                 build;
    logic                 rdy_emit;
    logic                 s1_adv;
    logic [1:0]           phase_inc;
    logic                 latch_now;
    logic [1:0]           n_phase;
    logic [7:0]           n_latched;
    logic [7:0]           checksum;
    sfs_pkg::t_frame_row  new_row;
    logic [7:0]           rd_data;
    logic [7:0]           s1_byte;

    assign s1_adv     = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign is_tick    = (i_in_data.func == sfs_pkg::FUNC_TICK);
    assign build      = in_acc && is_tick && (r_pacing_count == 8'd0);
    assign rdy_emit   = in_acc && (i_in_data.func == sfs_pkg::FUNC_READY) && !r_send_index[3];

    always_comb begin
        phase_inc = r_phase + 2'd1;
        latch_now = (phase_inc == LATCH_PHASE);
        n_phase   = latch_now ? 2'd0 : phase_inc;
        n_latched = latch_now ? i_in_data.sensed_value : r_latched;

        new_row[0] = sfs_pkg::HDR0;
        new_row[1] = sfs_pkg::HDR1;
        new_row[2] = {2'b00, i_in_data.status_flags};
        new_row[3] = i_in_data.speed_level;
        new_row[4] = i_in_data.battery_level;
        new_row[5] = n_latched;
        new_row[6] = i_in_data.logo_byte;
        checksum   = new_row[0] + new_row[1] + new_row[2] + new_row[3]
                   + new_row[4] + new_row[5] + new_row[6];
        new_row[7] = checksum;
    end

    sfs_frame_buf u_frame_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (build),
        .i_wr_row  (new_row),
        .i_rd_en   (rdy_emit),
        .i_rd_addr (r_send_index[sfs_pkg::INDEX_W-1:0]),
        .o_rd_data (rd_data)
    );

    // Byte 0 of a fresh frame is the header constant, so it skips the buffer.
    assign s1_byte = r_s1_direct ? sfs_pkg::HDR0 : rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload <= sfs_pkg::RELOAD_RESET;
        end else if (i_cfg_we) begin
            r_reload <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pacing_count <= sfs_pkg::RELOAD_RESET;
            r_phase        <= 2'd0;
            r_latched      <= 8'd0;
            r_send_index   <= 4'd0;
        end else if (in_acc) begin
            if (is_tick) begin
                if (r_pacing_count != 8'd0) begin
                    r_pacing_count <= r_pacing_count - 8'd1;
                end else begin
                    r_pacing_count <= r_reload;
                    r_phase        <= n_phase;
                    r_latched      <= n_latched;
                    r_send_index   <= 4'd1;
                end
            end else if (!r_send_index[3]) begin
                r_send_index <= r_send_index + 4'd1;
            end else begin
                r_send_index <= 4'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (build || rdy_emit) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (build) begin
            r_s1_direct <= 1'b1;
            r_s1_index  <= '0;
        end else if (rdy_emit) begin
            r_s1_direct <= 1'b0;
            r_s1_index  <= r_send_index[sfs_pkg::INDEX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_s1_valid && s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s1_adv) begin
            r_out_data.tx_byte    <= s1_byte;
            r_out_data.byte_index <= r_s1_index;
            r_out_data.frame_last <= (r_s1_index == sfs_pkg::INDEX_W'(sfs_pkg::FRAME_BYTES - 1));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    localparam int QUIET_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 6;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    sfs_pkg::t_in_beat   i_in_data = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    sfs_pkg::t_out_beat  o_out_data;
    logic                i_cfg_we = 1'b0;
    logic [7:0]          i_cfg_wdata = 8'd0;

    status_frame_sender DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Frame sender state as the predictor sees it.
    logic [7:0] pace_reload = sfs_pkg::RELOAD_RESET;
    logic [7:0] pace_cnt = sfs_pkg::RELOAD_RESET;
    logic [1:0] frame_phase = 2'd0;
    logic [7:0] sense_latch = 8'd0;
    logic [7:0] frame_bytes [sfs_pkg::FRAME_BYTES] = '{default: 8'd0};
    logic [3:0] send_pos = 4'd0;

    // Pacing counter as the stimulus planner tracks it ahead of the predictor.
    logic [7:0] plan_cnt = sfs_pkg::RELOAD_RESET;

    sfs_pkg::t_in_beat   pending_beats[$];
    sfs_pkg::t_out_beat  expected_tx_beats[$];
    t_idle_mode          idle_mode = IDLE_NONE;
    int                  fail_count = 0;
    int                  planned_beats = 0;
    int                  quiet_cycles = 0;

    function automatic void predict_tx_beat(input sfs_pkg::t_in_beat b);
        logic [7:0] sum;
        logic [2:0] idx;
        bit         sends;
        sends = 1'b0;
        idx = '0;
        if (b.func == sfs_pkg::FUNC_TICK) begin
            if (pace_cnt != 8'd0) begin
                pace_cnt = pace_cnt - 8'd1;
            end else begin
                pace_cnt = pace_reload;
                frame_phase = frame_phase + 2'd1;
                if (frame_phase == sfs_pkg::LATCH_EVERY) begin
                    frame_phase = 2'd0;
                    sense_latch = b.sensed_value;
                end
                frame_bytes[0] = sfs_pkg::HDR0;
                frame_bytes[1] = sfs_pkg::HDR1;
                frame_bytes[2] = {2'b00, b.status_flags};
                frame_bytes[3] = b.speed_level;
                frame_bytes[4] = b.battery_level;
                frame_bytes[5] = sense_latch;
                frame_bytes[6] = b.logo_byte;
                sum = 8'd0;
                for (int i = 0; i < sfs_pkg::FRAME_BYTES - 1; i++) sum = sum + frame_bytes[i];
                frame_bytes[sfs_pkg::FRAME_BYTES-1] = sum;
                sends = 1'b1;
                send_pos = 4'd1;
            end
        end else if (send_pos < sfs_pkg::FRAME_BYTES) begin
            sends = 1'b1;
            idx = send_pos[2:0];
            send_pos = send_pos + 4'd1;
        end else begin
            // One extra ready after the checksum only rewinds the index.
            send_pos = 4'd0;
        end
        if (sends) begin
            expected_tx_beats.push_back('{tx_byte: frame_bytes[idx], byte_index: idx,
                                          frame_last: (idx == sfs_pkg::FRAME_BYTES - 1)});
        end
    endfunction

    function automatic bit sender_idles();
        int roll;
        roll = $urandom_range(0, 99);
        return (idle_mode == IDLE_SEND && roll < 79) || (idle_mode == IDLE_BOTH && roll < 21);
    endfunction

    function automatic bit receiver_stalls();
        int roll;
        roll = $urandom_range(0, 99);
        return (idle_mode == IDLE_RECV && roll < 79) || (idle_mode == IDLE_BOTH && roll < 21);
    endfunction

    // Driver: a stalled beat is held; a new one is offered only after acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) predict_tx_beat(i_in_data);
            if (!i_in_valid || !o_in_stall) begin
                if (pending_beats.size() != 0 && !sender_idles()) begin
                    i_in_data <= pending_beats.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result beat against the oldest prediction.
    always @(posedge i_clk) begin
        sfs_pkg::t_out_beat want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_tx_beats.size() == 0) begin
                    $display("%0t: unexpected beat: tx_byte %h byte_index %0d frame_last %0b",
                             $time, o_out_data.tx_byte, o_out_data.byte_index,
                             o_out_data.frame_last);
                    fail_count++;
                end else begin
                    want = expected_tx_beats.pop_front();
                    if (o_out_data.tx_byte !== want.tx_byte) begin
                        $display("%0t: tx_byte expected %h actual %h",
                                 $time, want.tx_byte, o_out_data.tx_byte);
                        fail_count++;
                    end
                    if (o_out_data.byte_index !== want.byte_index) begin
                        $display("%0t: byte_index expected %0d actual %0d",
                                 $time, want.byte_index, o_out_data.byte_index);
                        fail_count++;
                    end
                    if (o_out_data.frame_last !== want.frame_last) begin
                        $display("%0t: frame_last expected %0b actual %0b",
                                 $time, want.frame_last, o_out_data.frame_last);
                        fail_count++;
                    end
                end
            end
            i_out_stall <= receiver_stalls();
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("[status_frame_sender] ERROR");
                $finish;
            end
        end
    end

    function automatic sfs_pkg::t_in_beat random_beat(input logic func);
        sfs_pkg::t_in_beat b;
        b.func = func;
        b.status_flags = 6'($urandom_range(0, 63));
        b.speed_level = 8'($urandom_range(0, 255));
        b.battery_level = 8'($urandom_range(0, 255));
        b.sensed_value = 8'($urandom_range(0, 255));
        b.logo_byte = 8'($urandom_range(0, 255));
        return b;
    endfunction

    // Queues a beat and returns 1 if it is the tick that builds a frame.
    function automatic bit plan_beat(input sfs_pkg::t_in_beat b);
        bit builds;
        builds = (b.func == sfs_pkg::FUNC_TICK) && (plan_cnt == 8'd0);
        if (b.func == sfs_pkg::FUNC_TICK) plan_cnt = builds ? pace_reload : plan_cnt - 8'd1;
        pending_beats.push_back(b);
        planned_beats++;
        return builds;
    endfunction

    task automatic plan_frame(input int readies);
        while (!plan_beat(random_beat(sfs_pkg::FUNC_TICK))) begin
        end
        repeat (readies) void'(plan_beat(random_beat(sfs_pkg::FUNC_READY)));
    endtask

    // Waits until the block is idle. Ticks and index clears give no result,
    // so a few more cycles pass for anything still in the pipeline.
    task automatic settle();
        while (pending_beats.size() != 0 || i_in_valid || expected_tx_beats.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reload(input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        pace_reload = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [7:0] reload, input t_idle_mode mode,
                             input int budget);
        int stop_at;
        int kind;
        settle();
        write_reload(reload);
        idle_mode = mode;
        stop_at = planned_beats + budget;
        while (planned_beats < stop_at) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                plan_frame(sfs_pkg::FRAME_BYTES - 1);
                if ($urandom_range(0, 1)) begin
                    void'(plan_beat(random_beat(sfs_pkg::FUNC_READY)));
                    if ($urandom_range(0, 3) == 0) begin
                        void'(plan_beat(random_beat(sfs_pkg::FUNC_READY)));
                    end
                end
            end else if (kind < 85) begin
                // Cut short; the next frame overwrites this one.
                plan_frame($urandom_range(0, 6));
            end else begin
                repeat ($urandom_range(1, 6))
                    void'(plan_beat(random_beat(logic'($urandom_range(0, 1)))));
            end
        end
    endtask

    initial begin
        sfs_pkg::t_in_beat b;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Straight after reset the frame store is all zero; send it and rewind.
        repeat (sfs_pkg::FRAME_BYTES + 1) void'(plan_beat(random_beat(sfs_pkg::FUNC_READY)));
        settle();
        write_reload(8'd0);
        // The counter still runs down from its reset value first.
        while (plan_cnt != 8'd0) void'(plan_beat(random_beat(sfs_pkg::FUNC_TICK)));
        b = '1;
        b.func = sfs_pkg::FUNC_TICK;
        void'(plan_beat(b));
        repeat (3) void'(plan_beat(random_beat(sfs_pkg::FUNC_READY)));
        void'(plan_beat('0));
        repeat (sfs_pkg::FRAME_BYTES) void'(plan_beat(random_beat(sfs_pkg::FUNC_READY)));
        void'(plan_beat(b));
        void'(plan_beat({sfs_pkg::FUNC_TICK, 6'h2A, 8'h55, 8'hAA, 8'h55, 8'hAA}));
        void'(plan_beat(random_beat(sfs_pkg::FUNC_READY)));

        run_phase(8'd0, IDLE_NONE, 50);
        run_phase(8'd1, IDLE_SEND, 50);
        run_phase(8'd2, IDLE_RECV, 50);
        run_phase(8'd3, IDLE_BOTH, 50);
        run_phase(8'($urandom_range(0, 6)), IDLE_NONE, 50);

        // Widest pacing: one quick frame, then the full 256-tick wait.
        settle();
        write_reload(8'd255);
        idle_mode = IDLE_BOTH;
        plan_frame(sfs_pkg::FRAME_BYTES - 1);
        plan_frame(sfs_pkg::FRAME_BYTES);

        settle();
        if (fail_count == 0) begin
            $display("[status_frame_sender] OK");
        end else begin
            $display("[status_frame_sender] ERROR");
        end
        $finish;
    end

endmodule
